FILE: sv/pcpr_pkg.sv
// Shared types and constants for the point cloud profile rasterizer.
// Used by every module of the block but pcpr_ram; depends on nothing else.
package pcpr_pkg;

  localparam int MAX_PIXELS      = 65536;
  localparam int ROT_FRAC_BITS   = 14;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int ADDR_W          = $clog2(MAX_PIXELS);

  localparam int COORD_W   = 32;
  localparam int TRIG_W    = 16;
  localparam int COLOR_W   = 24;
  localparam int INDEX_W   = 16;
  localparam int PROD_ROT_W = COORD_W + TRIG_W;           // one rotation product
  localparam int SUM_ROT_W  = PROD_ROT_W + 1;             // sum of two products
  localparam int ROT_W      = SUM_ROT_W - ROT_FRAC_BITS;  // rotated coordinate
  localparam int OFS_W      = ROT_W + 1;                  // offset from origin
  localparam int SCALE_HALF = 16;                         // scale split into two halves
  localparam int PROD_SCL_W = OFS_W + SCALE_HALF;
  localparam int HI_LIMIT_BITS = 40;
  localparam int PIX_SAT_BITS  = 33;
  localparam int PIX_W      = PIX_SAT_BITS + 2;           // signed pixel with saturation
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [COLOR_W-1:0] WHITE = {COLOR_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLOT  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STS_DONE = 2'd0,
    STS_CLIP = 2'd1,
    STS_OFF  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_COS    = 3'd0,
    CFG_ROT_SIN    = 3'd1,
    CFG_CLIP_MIN   = 3'd2,
    CFG_CLIP_MAX   = 3'd3,
    CFG_ORIGIN     = 3'd4,
    CFG_SCALE      = 3'd5,
    CFG_IMAGE_SIZE = 3'd6,
    CFG_VIEW_MODE  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TRIG_W-1:0] rot_cos;
    logic signed [TRIG_W-1:0] rot_sin;
    logic [63:0]              clip_min;
    logic [63:0]              clip_max;
    logic [63:0]              origin;
    logic [31:0]              scale;
    logic [31:0]              image_size;
    logic [1:0]               view_mode;
  } cfg_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    op_e                       op;
    logic                      clip_fail;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [COLOR_W-1:0]        color;
    logic [INDEX_W-1:0]        read_index;
  } cmd_t;

endpackage

FILE: sv/pcpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; the image store is one instance of it.
module pcpr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/pcpr_fifo.sv
// Short queue of classified items between the front and the back.
// Depends on pcpr_pkg.
module pcpr_fifo import pcpr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/pcpr_front.sv
// Input side: takes words from the input stream and runs the clip test.
// Depends on pcpr_pkg; feeds pcpr_fifo.
module pcpr_front import pcpr_pkg::*; (
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  cfg_t         cfg_i,
  input  logic         init_busy_i,
  input  logic         full_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  logic signed [COORD_W-1:0] x, y;
  logic signed [COORD_W-1:0] min_x, min_y, max_x, max_y;

  assign x     = $signed(s_axis_tdata[31:0]);
  assign y     = $signed(s_axis_tdata[63:32]);
  assign min_x = $signed(cfg_i.clip_min[31:0]);
  assign min_y = $signed(cfg_i.clip_min[63:32]);
  assign max_x = $signed(cfg_i.clip_max[31:0]);
  assign max_y = $signed(cfg_i.clip_max[63:32]);

  // The store sweep after reset must finish before any word is taken.
  assign s_axis_tready = !full_i && !init_busy_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd_o.op         = op_e'(s_axis_tuser);
    cmd_o.clip_fail  = (x < min_x) || (x > max_x) || (y < min_y) || (y > max_y);
    cmd_o.x          = x;
    cmd_o.y          = y;
    cmd_o.z          = $signed(s_axis_tdata[95:64]);
    cmd_o.color      = {s_axis_tdata[103:96], s_axis_tdata[111:104], s_axis_tdata[119:112]};
    cmd_o.read_index = s_axis_tdata[135:120];
  end

endmodule

FILE: sv/pcpr_back.sv
// Execution side: projection arithmetic, image store access, clear sweep
// and the output register. Depends on pcpr_pkg and pcpr_ram.
module pcpr_back import pcpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        init_busy_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser
);

  typedef enum logic [13:0] {
    S_INIT  = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_CLEAR = 14'b00000000000100,
    S_MUL   = 14'b00000000001000,
    S_ROT   = 14'b00000000010000,
    S_OFS   = 14'b00000000100000,
    S_ABS   = 14'b00000001000000,
    S_SCL   = 14'b00000010000000,
    S_PIX   = 14'b00000100000000,
    S_MAP   = 14'b00001000000000,
    S_ADR   = 14'b00010000000000,
    S_WR    = 14'b00100000000000,
    S_RD    = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_e;

  function automatic logic signed [PIX_W-1:0] to_pixel(input logic [PROD_SCL_W-1:0] hi,
                                                        input logic [PROD_SCL_W-1:0] lo,
                                                        input logic neg);
    logic [PROD_SCL_W+SCALE_HALF-1:0] sum;
    logic [PROD_SCL_W+SCALE_HALF-1:0] t;
    logic [PIX_SAT_BITS:0]            p;
    logic signed [PIX_W-1:0]          pe;
    sum = {hi, {SCALE_HALF{1'b0}}} + {{SCALE_HALF{1'b0}}, lo};
    t   = sum >> SCALE_FRAC_BITS;
    if (hi[PROD_SCL_W-1:HI_LIMIT_BITS] != '0 ||
        t[PROD_SCL_W+SCALE_HALF-1:PIX_SAT_BITS] != '0) begin
      p = {1'b1, {PIX_SAT_BITS{1'b0}}};
    end else begin
      p = {1'b0, t[PIX_SAT_BITS-1:0]};
    end
    pe = $signed({1'b0, p});
    return neg ? -pe : pe;
  endfunction

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;

  logic signed [PROD_ROT_W-1:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [SUM_ROT_W-1:0]  sum_u, sum_v;
  logic signed [ROT_W-1:0]      u_q, v_q;
  logic signed [OFS_W-1:0]      du_q, dv_q, du_d, dv_d;
  logic [OFS_W-1:0]             mu_q, mv_q;
  logic                         su_q, sv_q;
  logic [PROD_SCL_W-1:0]        uhi_q, ulo_q, vhi_q, vlo_q;
  logic signed [PIX_W-1:0]      col_q, row_q, cm, rm, we_s, he_s;
  logic                         off_q, off_d;
  logic [15:0]                  colx_q, rowx_q, img_w, img_h;
  logic [31:0]                  addr_q;
  logic                         addr_oor;

  status_e            res_status_q, res_status_d;
  logic [INDEX_W-1:0] res_index_q, res_index_d;
  logic [COLOR_W-1:0] res_color_q, res_color_d;

  logic               out_valid_q, out_valid_d, out_load;
  logic [39:0]        out_data_q;
  status_e            out_status_q;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COLOR_W-1:0] ram_wdata, ram_rdata;
  logic               head_oor;

  assign img_w    = cfg_i.image_size[15:0];
  assign img_h    = cfg_i.image_size[31:16];
  assign we_s     = $signed({{(PIX_W-16){1'b0}}, img_w});
  assign he_s     = $signed({{(PIX_W-16){1'b0}}, img_h});
  assign head_oor = (32'(head_i.read_index) >= 32'(MAX_PIXELS));
  assign addr_oor = (addr_q >= 32'(MAX_PIXELS));

  assign init_busy_o = (state_q == S_INIT);
  assign pop_o       = (state_q == S_IDLE) && !empty_i;

  // Rotation sums, floored by the arithmetic shift.
  assign sum_u = pxc_q + pys_q;
  assign sum_v = pyc_q - pxs_q;

  // Offsets from the origin; the vertical profile takes height for the row.
  always_comb begin
    du_d = $signed({{(OFS_W-ROT_W){u_q[ROT_W-1]}}, u_q}) -
           $signed({{(OFS_W-COORD_W){cfg_i.origin[31]}}, cfg_i.origin[31:0]});
    if (cfg_i.view_mode[0]) begin
      dv_d = $signed({{(OFS_W-COORD_W){cmd_q.z[COORD_W-1]}}, cmd_q.z}) -
             $signed({{(OFS_W-COORD_W){cfg_i.origin[63]}}, cfg_i.origin[63:32]});
    end else begin
      dv_d = $signed({{(OFS_W-ROT_W){v_q[ROT_W-1]}}, v_q}) -
             $signed({{(OFS_W-COORD_W){cfg_i.origin[63]}}, cfg_i.origin[63:32]});
    end
  end

  // Mirror and flip, then the image bounds test.
  always_comb begin
    cm = cfg_i.view_mode[1] ? (we_s - col_q - PIX_W'(1)) : col_q;
    rm = cfg_i.view_mode[0] ? (he_s - row_q - PIX_W'(1)) : row_q;
    off_d = cm[PIX_W-1] || (cm >= we_s) || rm[PIX_W-1] || (rm >= he_s);
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    ptr_d        = ptr_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_color_d  = res_color_q;
    ram_re       = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      S_INIT: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == ADDR_W'(MAX_PIXELS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty_i) begin
          cmd_d        = head_i;
          res_status_d = STS_DONE;
          res_index_d  = '0;
          res_color_d  = '0;
          case (head_i.op)
            OP_CLEAR: begin
              ptr_d   = '0;
              state_d = S_CLEAR;
            end
            OP_PLOT: begin
              if (head_i.clip_fail) begin
                res_status_d = STS_CLIP;
                state_d      = S_DONE;
              end else begin
                state_d = S_MUL;
              end
            end
            OP_READ: begin
              res_index_d = head_i.read_index;
              if (head_oor) begin
                res_status_d = STS_OFF;
                state_d      = S_DONE;
              end else begin
                ram_re  = 1'b1;
                state_d = S_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == ADDR_W'(MAX_PIXELS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_MUL: state_d = S_ROT;
      S_ROT: state_d = S_OFS;
      S_OFS: state_d = S_ABS;
      S_ABS: state_d = S_SCL;
      S_SCL: state_d = S_PIX;
      S_PIX: state_d = S_MAP;
      S_MAP: state_d = S_ADR;
      S_ADR: begin
        if (off_q) begin
          res_status_d = STS_OFF;
          state_d      = S_DONE;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        if (addr_oor) begin
          res_status_d = STS_OFF;
        end else begin
          res_index_d = addr_q[INDEX_W-1:0];
        end
        state_d = S_DONE;
      end
      S_RD: begin
        res_color_d = ram_rdata;
        res_index_d = cmd_q.read_index;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_color_q  <= res_color_d;
    if (state_q == S_MUL) begin
      pxc_q <= $signed(cmd_q.x) * $signed(cfg_i.rot_cos);
      pys_q <= $signed(cmd_q.y) * $signed(cfg_i.rot_sin);
      pyc_q <= $signed(cmd_q.y) * $signed(cfg_i.rot_cos);
      pxs_q <= $signed(cmd_q.x) * $signed(cfg_i.rot_sin);
    end
    if (state_q == S_ROT) begin
      u_q <= ROT_W'(sum_u >>> ROT_FRAC_BITS);
      v_q <= ROT_W'(sum_v >>> ROT_FRAC_BITS);
    end
    if (state_q == S_OFS) begin
      du_q <= du_d;
      dv_q <= dv_d;
    end
    if (state_q == S_ABS) begin
      su_q <= du_q[OFS_W-1];
      sv_q <= dv_q[OFS_W-1];
      mu_q <= du_q[OFS_W-1] ? OFS_W'(-du_q) : OFS_W'(du_q);
      mv_q <= dv_q[OFS_W-1] ? OFS_W'(-dv_q) : OFS_W'(dv_q);
    end
    // Full-width products: the destination width sizes the multiplication.
    if (state_q == S_SCL) begin
      uhi_q <= mu_q * cfg_i.scale[31:16];
      ulo_q <= mu_q * cfg_i.scale[15:0];
      vhi_q <= mv_q * cfg_i.scale[31:16];
      vlo_q <= mv_q * cfg_i.scale[15:0];
    end
    if (state_q == S_PIX) begin
      col_q <= to_pixel(uhi_q, ulo_q, su_q);
      row_q <= to_pixel(vhi_q, vlo_q, sv_q);
    end
    if (state_q == S_MAP) begin
      off_q  <= off_d;
      colx_q <= cm[15:0];
      rowx_q <= rm[15:0];
    end
    if (state_q == S_ADR) begin
      addr_q <= rowx_q * img_w + 32'(colx_q);
    end
    if (out_load) begin
      out_data_q   <= {res_color_q[7:0], res_color_q[15:8], res_color_q[23:16],
                       res_index_q};
      out_status_q <= res_status_q;
    end
  end

  // The sweep owns the write port during reset fill and clear.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = WHITE;
    if (state_q == S_INIT || state_q == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_q == S_WR) begin
      ram_we    = !addr_oor;
      ram_waddr = ADDR_W'(addr_q);
      ram_wdata = cmd_q.color;
    end
  end

  pcpr_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(MAX_PIXELS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ADDR_W'(head_i.read_index)),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

FILE: sv/point_cloud_profile_rasterizer.sv
// Point cloud profile rasterizer. One item is worked on at a time in the back
// sequencer, so it takes no new item before the last one has been passed to the
// output register; a two-entry queue keeps taking words meanwhile.
// After reset the image store is swept to white with s_axis_tready low;
// configuration writes are taken throughout.
module point_cloud_profile_rasterizer import pcpr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // x[31:0], y[63:32], z[95:64], red[103:96], green[111:104], blue[119:112],
  // read_index[135:120]
  input  logic [135:0]          s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,   // op[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_index[15:0], out_red[23:16], out_green[31:24], out_blue[39:32]
  output logic [39:0]           m_axis_tdata,
  output logic [1:0]            m_axis_tuser,   // status[1:0]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  cmd_t push_cmd, head;
  logic push, pop, full, empty, init_busy;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ROT_COS:    cfg_d.rot_cos    = $signed(cfg_data_i[TRIG_W-1:0]);
        CFG_ROT_SIN:    cfg_d.rot_sin    = $signed(cfg_data_i[TRIG_W-1:0]);
        CFG_CLIP_MIN:   cfg_d.clip_min   = cfg_data_i;
        CFG_CLIP_MAX:   cfg_d.clip_max   = cfg_data_i;
        CFG_ORIGIN:     cfg_d.origin     = cfg_data_i;
        CFG_SCALE:      cfg_d.scale      = cfg_data_i[31:0];
        CFG_IMAGE_SIZE: cfg_d.image_size = cfg_data_i[31:0];
        CFG_VIEW_MODE:  cfg_d.view_mode  = cfg_data_i[1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_cos    <= 16'sd16384;
      cfg_q.rot_sin    <= '0;
      cfg_q.clip_min   <= '0;
      cfg_q.clip_max   <= '1;
      cfg_q.origin     <= '0;
      cfg_q.scale      <= 32'd65536;
      cfg_q.image_size <= 32'd16777472;
      cfg_q.view_mode  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pcpr_front u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cfg_i        (cfg_q),
    .init_busy_i  (init_busy),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  pcpr_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (full),
    .empty_o    (empty)
  );

  pcpr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .init_busy_o  (init_busy),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
